### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pool allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// control check, sampled on the clock, off while reset is low
`define ASSERT_CTRL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("control check failed");

// result check, sampled on the clock, off while reset is low
`define ASSERT_DATA(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("result check failed");

`endif

### sv/ffpa_pkg.sv
// ---------------------------------------------------------------------------
// ffpa_pkg
// Types and constants of the first-fit pool allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int POOL_BYTES_DEF = 65536;
    localparam int REQ_W          = 17;
    localparam int OFS_W          = 16;
    localparam int NEED_W         = 18;
    localparam int HDR_BYTES      = 16;
    localparam int ROUND_MASK     = 'h1F;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STAT_DONE  = 1'b0;
    localparam logic STAT_NOFIT = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_FIT,
        ST_SPLIT,
        ST_LINK,
        ST_FREE
    } t_state;

endpackage

### sv/first_fit_pool_allocator_unit.sv
// ---------------------------------------------------------------------------
// first_fit_pool_allocator_unit
// First-fit allocator over a byte pool; free blocks form a singly linked list
// of 16-byte headers kept in one header RAM.
// ---------------------------------------------------------------------------
//  channel   ports                                             handshake
//  request   i_operation, i_request_size, i_freed_offset       start / busy
//  result    o_data_offset, o_status                           o_done strobe
//
//  Allocate: busy for the list walk (one header read per cycle), then through
//  ST_FIT and ST_LINK to unlink, or ST_FIT, ST_SPLIT and ST_LINK to split and relink.
//  No fit: busy for the walk only. Free: busy in ST_FREE (header read, then write);
//  a free below the first header completes without going busy. o_done follows.
//  Reset: afterwards ST_INIT writes the whole-pool header into slot 0 while busy.
//  The receiver cannot stall; each result shows for one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_fit_pool_allocator_unit #(
    parameter int POOL_BYTES = ffpa_pkg::POOL_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_operation,
    input  logic [ffpa_pkg::REQ_W-1:0] i_request_size,
    input  logic [ffpa_pkg::OFS_W-1:0] i_freed_offset,
    output logic                       o_done,
    output logic [ffpa_pkg::OFS_W-1:0] o_data_offset,
    output logic                       o_status
);

    import ffpa_pkg::*;

    localparam int SLOT_COUNT = POOL_BYTES / HDR_BYTES;
    localparam int AW         = $clog2(SLOT_COUNT);
    localparam int SL_W       = $clog2(SLOT_COUNT + 1);
    localparam int SZ_W       = $clog2(POOL_BYTES);
    localparam int CMP_W      = (SZ_W > NEED_W) ? SZ_W : NEED_W;
    localparam int TL_W       = ((SL_W > NEED_W - 4) ? SL_W : NEED_W - 4) + 1;
    localparam int IDX_W      = (SL_W > OFS_W - 4) ? SL_W : OFS_W - 4;
    localparam int OW         = (SL_W + 5 > OFS_W) ? SL_W + 5 : OFS_W;
    localparam int EW         = SZ_W + SL_W;

    localparam logic [SL_W-1:0] NULL_LINK = SL_W'(SLOT_COUNT);
    localparam logic [SZ_W-1:0] POOL_DATA = SZ_W'(SLOT_COUNT * HDR_BYTES - HDR_BYTES);

    t_state r_state, n_state;

    logic [SL_W-1:0]   r_head, n_head;
    logic [SL_W-1:0]   r_cur, n_cur;
    logic [SL_W-1:0]   r_prev, n_prev;
    logic              r_prev_vld, n_prev_vld;
    logic [SZ_W-1:0]   r_prev_size, n_prev_size;
    logic [SL_W-1:0]   r_steps, n_steps;
    logic [NEED_W-1:0] r_need, n_need;
    logic [SZ_W-1:0]   r_rem, n_rem;
    logic [SL_W-1:0]   r_clink, n_clink;
    logic [SL_W-1:0]   r_newlink, n_newlink;
    logic [IDX_W-1:0]  r_fslot, n_fslot;
    logic              r_done, n_done;
    logic [OFS_W-1:0]  r_offset, n_offset;
    logic              r_status, n_status;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;

    logic [SZ_W-1:0]   rd_size;
    logic [SL_W-1:0]   rd_link;
    logic [CMP_W:0]    diff;
    logic              fits;
    logic [SL_W-1:0]   step_nx;
    logic              walk_end;
    logic [TL_W-1:0]   tail;
    logic              split;
    logic [NEED_W-1:0] in_need;
    logic [IDX_W-1:0]  in_fslot;
    logic              free_ok;
    logic              head_null;
    logic [OW-1:0]     ofs_full;

    ffpa_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_size   = ram_rdata[SL_W +: SZ_W];
    assign rd_link   = ram_rdata[SL_W-1:0];

    // shared subtractor: fit test and remainder in one pass
    assign diff      = {1'b0, CMP_W'(rd_size)} - {1'b0, CMP_W'(r_need)};
    assign fits      = !diff[CMP_W];

    assign step_nx   = r_steps + SL_W'(1);
    assign walk_end  = (rd_link >= NULL_LINK) || (step_nx >= NULL_LINK);
    assign tail      = TL_W'(r_cur) + TL_W'(1) + TL_W'(r_need[NEED_W-1:4]);
    assign split     = (r_rem > SZ_W'(HDR_BYTES)) && (tail < TL_W'(SLOT_COUNT));

    assign in_need   = (NEED_W'(i_request_size) + NEED_W'(ROUND_MASK))
                       & ~NEED_W'(ROUND_MASK);
    assign in_fslot  = IDX_W'(i_freed_offset[OFS_W-1:4]) - IDX_W'(1);
    assign free_ok   = (i_freed_offset[OFS_W-1:4] != '0)
                       && (in_fslot < IDX_W'(SLOT_COUNT));
    assign head_null = (r_head >= NULL_LINK);
    assign ofs_full  = (OW'(r_cur) + OW'(1)) << 4;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_ALLOC) begin
                        n_state = head_null ? ST_IDLE : ST_WALK;
                    end else begin
                        n_state = free_ok ? ST_FREE : ST_IDLE;
                    end
                end
            end
            ST_WALK: begin
                if (fits) begin
                    n_state = ST_FIT;
                end else if (walk_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIT: begin
                n_state = split ? ST_SPLIT : ST_LINK;
            end
            ST_SPLIT: begin
                n_state = ST_LINK;
            end
            ST_LINK: begin
                n_state = ST_IDLE;
            end
            ST_FREE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_vld  = r_prev_vld;
        n_prev_size = r_prev_size;
        n_steps     = r_steps;
        n_need      = r_need;
        n_rem       = r_rem;
        n_clink     = r_clink;
        n_newlink   = r_newlink;
        n_fslot     = r_fslot;
        n_done      = 1'b0;
        n_offset    = r_offset;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {POOL_DATA, NULL_LINK};
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_operation == OP_ALLOC) begin
                        n_need     = in_need;
                        n_cur      = r_head;
                        n_prev_vld = 1'b0;
                        n_steps    = '0;
                        if (head_null) begin
                            n_done   = 1'b1;
                            n_offset = '0;
                            n_status = STAT_NOFIT;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_head[AW-1:0];
                        end
                    end else begin
                        n_offset = i_freed_offset;
                        n_status = STAT_DONE;
                        n_fslot  = in_fslot;
                        if (free_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = in_fslot[AW-1:0];
                        end else begin
                            n_done = 1'b1;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (fits) begin
                    n_rem   = diff[SZ_W-1:0];
                    n_clink = rd_link;
                end else if (walk_end) begin
                    n_done   = 1'b1;
                    n_offset = '0;
                    n_status = STAT_NOFIT;
                end else begin
                    n_prev      = r_cur;
                    n_prev_size = rd_size;
                    n_prev_vld  = 1'b1;
                    n_cur       = rd_link;
                    n_steps     = step_nx;
                    ram_re      = 1'b1;
                    ram_raddr   = rd_link[AW-1:0];
                end
            end
            ST_FIT: begin
                if (split) begin
                    ram_we    = 1'b1;
                    ram_waddr = tail[AW-1:0];
                    ram_wdata = {r_rem - SZ_W'(HDR_BYTES), r_clink};
                    n_newlink = tail[SL_W-1:0];
                    // keep the new tail size when the tail header is the predecessor
                    if (r_prev_vld && (tail[SL_W-1:0] == r_prev)) begin
                        n_prev_size = r_rem - SZ_W'(HDR_BYTES);
                    end
                end else begin
                    n_newlink = r_clink;
                end
            end
            ST_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[AW-1:0];
                ram_wdata = {SZ_W'(r_need), r_clink};
            end
            ST_LINK: begin
                if (r_prev_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev[AW-1:0];
                    ram_wdata = {r_prev_size, r_newlink};
                end else begin
                    n_head = r_newlink;
                end
                n_done   = 1'b1;
                n_offset = ofs_full[OFS_W-1:0];
                n_status = STAT_DONE;
            end
            ST_FREE: begin
                ram_we    = 1'b1;
                ram_waddr = r_fslot[AW-1:0];
                ram_wdata = {rd_size, r_head};
                n_head    = r_fslot[SL_W-1:0];
                n_done    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_head  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_prev_vld  <= n_prev_vld;
        r_prev_size <= n_prev_size;
        r_steps     <= n_steps;
        r_need      <= n_need;
        r_rem       <= n_rem;
        r_clink     <= n_clink;
        r_newlink   <= n_newlink;
        r_fslot     <= n_fslot;
        r_offset    <= n_offset;
        r_status    <= n_status;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_data_offset = r_offset;
    assign o_status      = r_status;

    `ASSERT_CTRL(a_walk_in_pool, i_clk, i_rst_n,
        (r_state == ST_WALK) |-> ((r_cur < NULL_LINK) && (r_steps < NULL_LINK)))
    `ASSERT_CTRL(a_ram_one_access, i_clk, i_rst_n, !(ram_we && ram_re))
    `ASSERT_DATA(a_done_has_cause, i_clk, i_rst_n,
        o_done |-> ($past(r_state) != ST_IDLE || $past(start)))
    `ASSERT_DATA(a_nofit_zero, i_clk, i_rst_n,
        (o_done && (o_status == STAT_NOFIT)) |-> (o_data_offset == '0))

endmodule

### sv/ffpa_ram.sv
// ---------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sim/tb_first_fit_pool_allocator_unit.sv
// ---------------------------------------------------------------------------
// tb_first_fit_pool_allocator_unit
// Self-checking bench for the first-fit pool allocator. A directed table
// covers the pool extremes, zero and oversize requests, frees below the
// first header, misaligned frees, exact fits and splits. Random traffic
// then allocates and releases blocks. A short closing sequence frees one
// block twice to close the free list on itself. Every result is checked
// against its table entry or a local model of the free list and header store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_pool_allocator_unit;
    import ffpa_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  SLOT_COUNT  = POOL_BYTES_DEF / HDR_BYTES;
    localparam int  NULL_LINK   = SLOT_COUNT;
    localparam int  N_RANDOM    = 1630;
    localparam int  N_QUIET     = 200;
    localparam int  CYCLE_LIMIT = 40_000_000;
    localparam int  N_DIRECTED  = 22;
    localparam bit  ROW_TYPED   = 1'b1;
    localparam bit  ROW_PRED    = 1'b0;

    typedef struct packed {
        logic        op;
        logic [16:0] size;
        logic [15:0] ofs;
        logic        typed;
        logic [15:0] exp_ofs;
        logic        exp_stat;
    } t_pool_req;

    typedef struct packed {
        logic [15:0] ofs;
        logic        stat;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [16:0] i_request_size;
    logic [15:0] i_freed_offset;
    logic        o_done;
    logic [15:0] o_data_offset;
    logic        o_status;

    bit [16:0] hdr_size [SLOT_COUNT];
    bit [12:0] hdr_link [SLOT_COUNT];
    bit [12:0] free_head;
    int        live_slots [$];
    t_reply    pool_reply_q [$];

    int errors;
    int cycle_count;
    int n_checked;
    int n_granted;
    int n_refused;
    int n_released;
    bit idle_on;

    t_pool_req directed_reqs [N_DIRECTED] = '{
        '{OP_ALLOC, 17'd0,     16'd0,   ROW_TYPED, 16'd16,  STAT_DONE},
        '{OP_ALLOC, 17'd65536, 16'd0,   ROW_TYPED, 16'd0,   STAT_NOFIT},
        '{OP_ALLOC, 17'd1,     16'd0,   ROW_TYPED, 16'd32,  STAT_DONE},
        '{OP_FREE,  17'd0,     16'd16,  ROW_TYPED, 16'd16,  STAT_DONE},
        '{OP_ALLOC, 17'd0,     16'd0,   ROW_PRED,  16'd0,   STAT_DONE},
        '{OP_FREE,  17'd0,     16'd5,   ROW_TYPED, 16'd5,   STAT_DONE},
        '{OP_FREE,  17'h1FFFF, 16'd0,   ROW_TYPED, 16'd0,   STAT_DONE},
        '{OP_FREE,  17'd0,     16'd15,  ROW_TYPED, 16'd15,  STAT_DONE},
        '{OP_ALLOC, 17'd65536, 16'hFFFF, ROW_TYPED, 16'd0,  STAT_NOFIT},
        '{OP_ALLOC, 17'd65440, 16'd0,   ROW_PRED,  16'd0,   STAT_DONE},
        '{OP_ALLOC, 17'd0,     16'd0,   ROW_TYPED, 16'd0,   STAT_NOFIT},
        '{OP_FREE,  17'd0,     16'd47,  ROW_TYPED, 16'd47,  STAT_DONE},
        '{OP_ALLOC, 17'd33,    16'd0,   ROW_TYPED, 16'd0,   STAT_NOFIT},
        '{OP_ALLOC, 17'd32,    16'd0,   ROW_PRED,  16'd0,   STAT_DONE},
        '{OP_FREE,  17'd0,     16'd80,  ROW_TYPED, 16'd80,  STAT_DONE},
        '{OP_FREE,  17'd0,     16'd16,  ROW_TYPED, 16'd16,  STAT_DONE},
        '{OP_ALLOC, 17'd65430, 16'd0,   ROW_PRED,  16'd0,   STAT_DONE},
        '{OP_FREE,  17'd0,     16'd80,  ROW_TYPED, 16'd80,  STAT_DONE},
        '{OP_ALLOC, 17'd100,   16'd0,   ROW_PRED,  16'd0,   STAT_DONE},
        '{OP_ALLOC, 17'd65312, 16'd0,   ROW_PRED,  16'd0,   STAT_DONE},
        '{OP_ALLOC, 17'd1,     16'd0,   ROW_TYPED, 16'd0,   STAT_NOFIT},
        '{OP_FREE,  17'd0,     16'd224, ROW_TYPED, 16'd224, STAT_DONE}
    };

    first_fit_pool_allocator_unit #(
        .POOL_BYTES(POOL_BYTES_DEF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_request_size (i_request_size),
        .i_freed_offset (i_freed_offset),
        .o_done         (o_done),
        .o_data_offset  (o_data_offset),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic void relink(int prev, int target);
        if (prev < SLOT_COUNT) begin
            hdr_link[prev] = 13'(target);
        end else begin
            free_head = 13'(target);
        end
    endfunction

    task automatic predict_pool_op(input logic op, input logic [16:0] size,
                                   input logic [15:0] ofs,
                                   output logic [15:0] r_ofs, output logic r_stat);
        int need;
        int prev;
        int cur;
        int steps;
        int slot;
        int tail;
        bit found;
        if (op == OP_FREE) begin
            if (ofs >= HDR_BYTES) begin
                slot = int'(ofs >> 4) - 1;
                if (slot < SLOT_COUNT) begin
                    hdr_link[slot] = free_head;
                    free_head = 13'(slot);
                    for (int k = 0; k < live_slots.size(); k++) begin
                        if (live_slots[k] == slot) begin
                            live_slots.delete(k);
                            break;
                        end
                    end
                end
            end
            r_ofs = ofs;
            r_stat = STAT_DONE;
            n_released++;
        end else begin
            need = (int'(size) + ROUND_MASK) & ~ROUND_MASK;
            prev = NULL_LINK;
            cur = int'(free_head);
            steps = 0;
            found = 1'b0;
            while (cur < SLOT_COUNT && steps < SLOT_COUNT) begin
                if (int'(hdr_size[cur]) >= need) begin
                    found = 1'b1;
                    break;
                end
                prev = cur;
                cur = int'(hdr_link[cur]);
                steps++;
            end
            if (!found) begin
                r_ofs = '0;
                r_stat = STAT_NOFIT;
                n_refused++;
            end else begin
                tail = cur + 1 + (need >> 4);
                if (int'(hdr_size[cur]) > need + HDR_BYTES && tail < SLOT_COUNT) begin
                    hdr_size[tail] = 17'(int'(hdr_size[cur]) - HDR_BYTES - need);
                    hdr_link[tail] = hdr_link[cur];
                    hdr_size[cur] = 17'(need);
                    relink(prev, tail);
                end else begin
                    relink(prev, int'(hdr_link[cur]));
                end
                live_slots.push_back(cur);
                r_ofs = 16'((cur + 1) * HDR_BYTES);
                r_stat = STAT_DONE;
                n_granted++;
            end
        end
    endtask

    task automatic send_request(input logic op, input logic [16:0] size,
                                input logic [15:0] ofs, input bit typed,
                                input logic [15:0] exp_ofs, input logic exp_stat);
        logic [15:0] p_ofs;
        logic        p_stat;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_operation    <= op;
        i_request_size <= size;
        i_freed_offset <= ofs;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
        predict_pool_op(op, size, ofs, p_ofs, p_stat);
        if (typed) begin
            pool_reply_q.push_back(t_reply'{exp_ofs, exp_stat});
        end else begin
            pool_reply_q.push_back(t_reply'{p_ofs, p_stat});
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped at cycle limit", $time);
            $display("first_fit_pool_allocator_unit test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pool_reply_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ofs %0d status %0d",
                         $time, o_data_offset, o_status);
                errors++;
            end else begin
                exp_r = pool_reply_q.pop_front();
                n_checked++;
                if (o_data_offset !== exp_r.ofs) begin
                    $display("%0t: data_offset mismatch, expected %0d, actual %0d",
                             $time, exp_r.ofs, o_data_offset);
                    errors++;
                end
                if (o_status !== exp_r.stat) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_r.stat, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        int          pick;
        int          idx;
        int          victim;
        logic [16:0] size;
        logic [15:0] ofs;
        errors         = 0;
        cycle_count    = 0;
        n_checked      = 0;
        n_granted      = 0;
        n_refused      = 0;
        n_released     = 0;
        idle_on        = 1'b1;
        hdr_size[0]    = 17'(SLOT_COUNT * HDR_BYTES - HDR_BYTES);
        hdr_link[0]    = 13'(NULL_LINK);
        free_head      = '0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_operation    <= OP_ALLOC;
        i_request_size <= '0;
        i_freed_offset <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(directed_reqs[r].op, directed_reqs[r].size, directed_reqs[r].ofs,
                         directed_reqs[r].typed, directed_reqs[r].exp_ofs,
                         directed_reqs[r].exp_stat);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            idle_on = (i < N_RANDOM - N_QUIET) && ((i / 150) % 2 == 0);
            pick = $urandom_range(0, 99);
            if (live_slots.size() == 0 || pick < 52) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) size = 17'($urandom_range(0, 255));
                else if (pick < 85) size = 17'($urandom_range(0, 2047));
                else if (pick < 97) size = 17'($urandom_range(0, 16383));
                else size = 17'($urandom_range(0, 65536));
                send_request(OP_ALLOC, size, 16'($urandom), ROW_PRED, '0, STAT_DONE);
            end else if (pick < 95) begin
                idx = $urandom_range(0, live_slots.size() - 1);
                ofs = 16'((live_slots[idx] + 1) * HDR_BYTES);
                if ($urandom_range(0, 3) == 0) ofs = ofs | 16'($urandom_range(1, 15));
                send_request(OP_FREE, 17'($urandom), ofs, ROW_PRED, '0, STAT_DONE);
            end else begin
                send_request(OP_FREE, 17'($urandom), 16'($urandom_range(0, 15)),
                             ROW_PRED, '0, STAT_DONE);
            end
        end

        // free one block twice so the list loops back on itself
        if (live_slots.size() != 0) begin
            victim = live_slots[0];
            ofs = 16'((victim + 1) * HDR_BYTES);
            send_request(OP_FREE, '0, ofs, ROW_TYPED, ofs, STAT_DONE);
            send_request(OP_FREE, '0, ofs, ROW_TYPED, ofs, STAT_DONE);
            send_request(OP_ALLOC, 17'd65536, '0, ROW_TYPED, '0, STAT_NOFIT);
            send_request(OP_ALLOC, 17'd0, '0, ROW_TYPED, ofs, STAT_DONE);
        end
        start <= 1'b0;

        while (pool_reply_q.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("checked %0d results: %0d blocks granted, %0d requests refused, %0d frees",
                 n_checked, n_granted, n_refused, n_released);
        $display("%0d blocks still allocated, %0d mismatches", live_slots.size(), errors);
        if (errors == 0) begin
            $display("first_fit_pool_allocator_unit test passed");
        end else begin
            $display("first_fit_pool_allocator_unit test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/ffpa_pkg.sv
sv/ffpa_ram.sv
sv/first_fit_pool_allocator_unit.sv
sim/tb_first_fit_pool_allocator_unit.sv
